@@ src/fta_pkg.sv @@
package fta_pkg;

  localparam int MAX_ENTRIES  = 256;
  localparam int BLOCK_BYTES  = 512;
  localparam int HEADER_BYTES = 512;
  localparam int TABLE_BYTES  = 16384;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  // offset of the first file, one block past the end of header and table
  localparam logic [33:0] FIRST_OFF =
    34'(((HEADER_BYTES + TABLE_BYTES) / BLOCK_BYTES + 1) * BLOCK_BYTES);

  typedef logic [1:0] op_t;
  localparam op_t OP_FORMAT = 2'd0;
  localparam op_t OP_OPEN   = 2'd1;
  localparam op_t OP_FIND   = 2'd2;
  localparam op_t OP_DELETE = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_CREATED  = 3'd1;
  localparam status_t ST_NOTFOUND = 3'd2;
  localparam status_t ST_NOSPACE  = 3'd3;
  localparam status_t ST_FULL     = 3'd4;
  localparam status_t ST_OFF      = 3'd5;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ENABLED  = 2'd0;
  localparam cfg_idx_t CFG_CAPACITY = 2'd1;
  localparam cfg_idx_t CFG_MIN_SIZE = 2'd2;

  // one table entry; unused is implied by index >= entry count
  typedef struct packed {
    logic        deleted;
    logic [63:0] key;
    logic [31:0] length;
    logic [31:0] start;
  } entry_t;

endpackage

@@ src/fta_if.sv @@
interface fta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] file_name;
  logic [31:0] file_size;
  logic [7:0]  entry_index;

  modport source (output valid, operation, file_name, file_size, entry_index, input ready);
  modport sink (input valid, operation, file_name, file_size, entry_index, output ready);
endinterface

interface fta_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  result_index;
  logic [31:0] file_offset;
  logic [31:0] result_size;
  logic [31:0] used_total;

  modport source (output valid, status, result_index, file_offset, result_size, used_total,
                  input ready);
  modport sink (input valid, status, result_index, file_offset, result_size, used_total,
                output ready);
endinterface

@@ src/file_table_allocator_core.sv @@
// Format and disabled operations pass through S_QUICK, delete through S_DEL;
// open and find scan the table in S_SCAN and settle in S_DECIDE, open with a new
// placement also in S_PLACE; the result states wait for a free output register.
// Throughput: one operation at a time, bounded by the table scan through the
// single read port of the entry memory, one entry a cycle.
// Reset: synchronous active-low rst_n clears counters, control and registers;
// the entry memory needs no clearing since entries past entry_count are unused.
module file_table_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  fta_in_if.sink      in_ch,
  fta_out_if.source   out_ch
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_DEL    = 3'd4;
  localparam logic [2:0] S_QUICK  = 3'd5;

  localparam int IW = fta_pkg::IDX_W;
  localparam int CW = fta_pkg::CNT_W;

  logic [2:0]  state_r;
  logic        enabled_r;
  logic [31:0] capacity_r;
  logic [31:0] min_size_r;

  logic [CW-1:0] count_r;
  logic [31:0]   used_r;
  logic [31:0]   alloc_r;

  // operation in flight
  logic [1:0]        op_r;
  logic [63:0]       key_r;
  logic [31:0]       size_r;
  logic [IW-1:0]     del_idx_r;
  fta_pkg::status_t  quick_st_r;

  // scan bookkeeping
  logic [CW-1:0] scan_idx_r;
  logic          pend_r;
  logic [IW-1:0] pidx_r;
  logic          hit_v_r;
  logic [IW-1:0] hit_idx_r;
  logic [31:0]   hit_start_r;
  logic [31:0]   hit_len_r;
  logic          best_v_r;
  logic [IW-1:0] best_idx_r;
  logic [31:0]   best_start_r;
  logic [31:0]   best_len_r;
  logic [32:0]   last_end_r;
  logic [33:0]   off_r;

  // entry memory
  fta_pkg::entry_t mem [fta_pkg::MAX_ENTRIES];
  fta_pkg::entry_t mem_q;
  logic [IW-1:0]   rd_addr;
  logic            we;
  logic [IW-1:0]   waddr;
  fta_pkg::entry_t wdata;

  // output register
  logic             out_vld_r;
  fta_pkg::status_t out_st_r;
  logic [7:0]       out_idx_r;
  logic [31:0]      out_off_r;
  logic [31:0]      out_size_r;
  logic [31:0]      out_used_r;

  logic in_acc;
  logic out_free;
  logic scan_issue;
  logic [34:0] place_sum;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_free      = !out_vld_r || out_ch.ready;
  assign scan_issue    = (state_r == S_SCAN) && (scan_idx_r < count_r);
  assign place_sum     = {1'b0, off_r} + {3'b0, size_r};

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.file_offset  = out_off_r;
  assign out_ch.result_size  = out_size_r;
  assign out_ch.used_total   = out_used_r;

  // select read address: delete index at accept, scan pointer, held delete index
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = in_ch.entry_index[IW-1:0];
      S_SCAN:  rd_addr = scan_idx_r[IW-1:0];
      default: rd_addr = del_idx_r;
    endcase
  end

  // entry memory write requests
  always_comb begin
    we    = 1'b0;
    waddr = best_idx_r;
    wdata = '{deleted: 1'b0, key: key_r, length: size_r, start: best_start_r};
    case (state_r)
      S_DECIDE: begin
        if (out_free && op_r == fta_pkg::OP_OPEN && !hit_v_r && best_v_r) begin
          we = 1'b1;
        end
      end
      S_PLACE: begin
        if (out_free && place_sum < {3'b0, capacity_r}) begin
          we    = 1'b1;
          waddr = count_r[IW-1:0];
          wdata = '{deleted: 1'b0, key: key_r, length: size_r, start: off_r[31:0]};
        end
      end
      S_DEL: begin
        if (out_free && {1'b0, del_idx_r} < count_r && !mem_q.deleted) begin
          we            = 1'b1;
          waddr         = del_idx_r;
          wdata         = mem_q;
          wdata.deleted = 1'b1;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      capacity_r <= '0;
      min_size_r <= 32'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        fta_pkg::CFG_ENABLED:  enabled_r  <= cfg_data[0];
        fta_pkg::CFG_CAPACITY: capacity_r <= cfg_data;
        fta_pkg::CFG_MIN_SIZE: min_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the operation and collect scan results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_ch.operation;
      key_r      <= in_ch.file_name;
      size_r     <= (in_ch.file_size < min_size_r) ? min_size_r : in_ch.file_size;
      del_idx_r  <= in_ch.entry_index[IW-1:0];
      quick_st_r <= enabled_r ? fta_pkg::ST_OK : fta_pkg::ST_OFF;
      scan_idx_r <= '0;
      hit_v_r    <= 1'b0;
      best_v_r   <= 1'b0;
    end
    if (scan_issue) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    pidx_r <= scan_idx_r[IW-1:0];
    if (pend_r) begin
      last_end_r <= {1'b0, mem_q.start} + {1'b0, mem_q.length};
      if (!hit_v_r && mem_q.key == key_r) begin
        hit_v_r     <= 1'b1;
        hit_idx_r   <= pidx_r;
        hit_start_r <= mem_q.start;
        hit_len_r   <= mem_q.length;
      end
      if (mem_q.deleted && mem_q.length >= size_r &&
          (!best_v_r || mem_q.length < best_len_r)) begin
        best_v_r     <= 1'b1;
        best_idx_r   <= pidx_r;
        best_start_r <= mem_q.start;
        best_len_r   <= mem_q.length;
      end
    end
    if (state_r == S_DECIDE) begin
      off_r <= (count_r == '0) ? fta_pkg::FIRST_OFF :
               34'(({1'b0, last_end_r} / fta_pkg::BLOCK_BYTES + 34'd1) * fta_pkg::BLOCK_BYTES);
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pend_r    <= 1'b0;
      count_r   <= '0;
      used_r    <= '0;
      alloc_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      pend_r <= scan_issue;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!enabled_r || in_ch.operation == fta_pkg::OP_FORMAT) begin
              state_r <= S_QUICK;
            end else if (in_ch.operation == fta_pkg::OP_DELETE) begin
              state_r <= S_DEL;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!scan_issue && !pend_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_QUICK: begin
          if (out_free) begin
            out_vld_r  <= 1'b1;
            out_st_r   <= quick_st_r;
            out_idx_r  <= '0;
            out_off_r  <= '0;
            out_size_r <= '0;
            if (quick_st_r == fta_pkg::ST_OK) begin
              count_r    <= '0;
              used_r     <= '0;
              alloc_r    <= '0;
              out_used_r <= '0;
            end else begin
              out_used_r <= used_r;
            end
            state_r <= S_IDLE;
          end
        end
        S_DEL: begin
          if (out_free) begin
            out_vld_r <= 1'b1;
            if ({1'b0, del_idx_r} < count_r && !mem_q.deleted) begin
              used_r     <= used_r - mem_q.length;
              out_st_r   <= fta_pkg::ST_OK;
              out_idx_r  <= 8'(del_idx_r);
              out_off_r  <= mem_q.start;
              out_size_r <= mem_q.length;
              out_used_r <= used_r - mem_q.length;
            end else begin
              out_st_r   <= fta_pkg::ST_NOTFOUND;
              out_idx_r  <= '0;
              out_off_r  <= '0;
              out_size_r <= '0;
              out_used_r <= used_r;
            end
            state_r <= S_IDLE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_used_r <= used_r;
            out_idx_r  <= '0;
            out_off_r  <= '0;
            out_size_r <= '0;
            state_r    <= S_IDLE;
            if (hit_v_r) begin
              out_vld_r  <= 1'b1;
              out_st_r   <= fta_pkg::ST_OK;
              out_idx_r  <= 8'(hit_idx_r);
              out_off_r  <= hit_start_r;
              out_size_r <= hit_len_r;
            end else if (op_r == fta_pkg::OP_FIND) begin
              out_vld_r <= 1'b1;
              out_st_r  <= fta_pkg::ST_NOTFOUND;
            end else if (best_v_r) begin
              // reclaim a deleted entry, keep its offset
              out_vld_r  <= 1'b1;
              out_st_r   <= fta_pkg::ST_CREATED;
              out_idx_r  <= 8'(best_idx_r);
              out_off_r  <= best_start_r;
              out_size_r <= size_r;
              used_r     <= used_r + size_r;
              out_used_r <= used_r + size_r;
            end else if (count_r == CW'(fta_pkg::MAX_ENTRIES)) begin
              out_vld_r <= 1'b1;
              out_st_r  <= fta_pkg::ST_FULL;
            end else begin
              state_r <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          if (out_free) begin
            out_vld_r  <= 1'b1;
            state_r    <= S_IDLE;
            if (place_sum < {3'b0, capacity_r}) begin
              out_st_r   <= fta_pkg::ST_CREATED;
              out_idx_r  <= 8'(count_r[IW-1:0]);
              out_off_r  <= off_r[31:0];
              out_size_r <= size_r;
              count_r    <= count_r + 1'b1;
              used_r     <= used_r + size_r;
              alloc_r    <= alloc_r + size_r;
              out_used_r <= used_r + size_r;
            end else begin
              out_st_r   <= fta_pkg::ST_NOSPACE;
              out_idx_r  <= '0;
              out_off_r  <= '0;
              out_size_r <= '0;
              out_used_r <= used_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(fta_pkg::MAX_ENTRIES))
    else $error("entry count beyond table size");
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_SCAN && we))
    else $error("entry write during table scan");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted beat did not start an operation");
  a_alloc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r) == S_QUICK && $past(quick_st_r) == fta_pkg::ST_OK
     && $past(out_free) && $past(rst_n)) |-> (count_r == '0 && alloc_r == '0))
    else $error("format left counters set");
`endif

endmodule

@@ tb/fta_checker.sv @@
`timescale 1ns / 1ps

module fta_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  fta_in_if           in_ch,
  fta_out_if          out_ch,
  output int          fail_count,
  output int          open_count
);

  typedef enum logic [1:0] {SLOT_FREE, SLOT_LIVE, SLOT_GONE} slot_t;

  typedef struct {
    fta_pkg::status_t status;
    logic [7:0]       index;
    logic [31:0]      offset;
    logic [31:0]      size;
    logic [31:0]      used;
  } answer_t;

  slot_t       slot_state [fta_pkg::MAX_ENTRIES];
  logic [63:0] slot_key   [fta_pkg::MAX_ENTRIES];
  logic [31:0] slot_len   [fta_pkg::MAX_ENTRIES];
  logic [31:0] slot_off   [fta_pkg::MAX_ENTRIES];
  int          live_slots;
  logic [31:0] used_bytes;
  logic [31:0] alloc_bytes;
  logic        fs_on;
  logic [31:0] capacity;
  logic [31:0] min_size;

  answer_t answers_due[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("fta_checker: %s mismatch: got %0h, expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void wipe_table();
    for (int i = 0; i < fta_pkg::MAX_ENTRIES; i++) slot_state[i] = SLOT_FREE;
    live_slots  = 0;
    used_bytes  = '0;
    alloc_bytes = '0;
  endfunction

  function automatic answer_t with_slot(input fta_pkg::status_t st, input int i);
    answer_t a;
    a.status = st;
    a.index  = 8'(i);
    a.offset = slot_off[i];
    a.size   = slot_len[i];
    a.used   = used_bytes;
    return a;
  endfunction

  function automatic answer_t bare(input fta_pkg::status_t st);
    answer_t a;
    a.status = st;
    a.index  = '0;
    a.offset = '0;
    a.size   = '0;
    a.used   = used_bytes;
    return a;
  endfunction

  function automatic int find_name(input logic [63:0] key);
    int seen;
    seen = 0;
    for (int i = 0; i < fta_pkg::MAX_ENTRIES && seen < live_slots; i++) begin
      if (slot_state[i] != SLOT_FREE) begin
        seen++;
        if (slot_key[i] == key) return i;
      end
    end
    return -1;
  endfunction

  // best-fit reclaim first, else bump placement into the first free slot
  function automatic answer_t place_file(input logic [63:0] key, input logic [31:0] size);
    int          seen, best, i;
    logic [31:0] best_len;
    logic [63:0] off;
    seen = 0;
    best = -1;
    best_len = '0;
    for (i = 0; i < fta_pkg::MAX_ENTRIES && seen < live_slots; i++) begin
      if (slot_state[i] == SLOT_FREE) break;
      seen++;
      if (slot_state[i] == SLOT_GONE && slot_len[i] >= size &&
          (best < 0 || slot_len[i] < best_len)) begin
        best = i;
        best_len = slot_len[i];
      end
    end
    if (best >= 0) begin
      slot_key[best]   = key;
      slot_len[best]   = size;
      slot_state[best] = SLOT_LIVE;
      used_bytes += size;
      return with_slot(fta_pkg::ST_CREATED, best);
    end
    for (i = 0; i < fta_pkg::MAX_ENTRIES; i++)
      if (slot_state[i] == SLOT_FREE) break;
    if (i >= fta_pkg::MAX_ENTRIES) return bare(fta_pkg::ST_FULL);
    if (i == 0)
      off = 64'(fta_pkg::FIRST_OFF);
    else
      off = ((64'(slot_off[i-1]) + 64'(slot_len[i-1])) / fta_pkg::BLOCK_BYTES + 1)
            * fta_pkg::BLOCK_BYTES;
    if (off + 64'(size) >= 64'(capacity)) return bare(fta_pkg::ST_NOSPACE);
    slot_state[i] = SLOT_LIVE;
    slot_key[i]   = key;
    slot_len[i]   = size;
    slot_off[i]   = off[31:0];
    alloc_bytes += size;
    live_slots++;
    used_bytes += size;
    return with_slot(fta_pkg::ST_CREATED, i);
  endfunction

  function automatic answer_t apply_op(input fta_pkg::op_t op, input logic [63:0] key,
                                       input logic [31:0] size, input logic [7:0] del);
    int          hit;
    logic [31:0] want;
    if (!fs_on) return bare(fta_pkg::ST_OFF);
    case (op)
      fta_pkg::OP_FORMAT: begin
        wipe_table();
        return bare(fta_pkg::ST_OK);
      end
      fta_pkg::OP_OPEN: begin
        want = (size < min_size) ? min_size : size;
        hit = find_name(key);
        if (hit >= 0) return with_slot(fta_pkg::ST_OK, hit);
        return place_file(key, want);
      end
      fta_pkg::OP_FIND: begin
        hit = find_name(key);
        if (hit >= 0) return with_slot(fta_pkg::ST_OK, hit);
        return bare(fta_pkg::ST_NOTFOUND);
      end
      default: begin
        if (slot_state[del] == SLOT_LIVE) begin
          slot_state[del] = SLOT_GONE;
          used_bytes -= slot_len[del];
          return with_slot(fta_pkg::ST_OK, int'(del));
        end
        return bare(fta_pkg::ST_NOTFOUND);
      end
    endcase
  endfunction

  // track config, predict each accepted beat, compare each result beat
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      wipe_table();
      fs_on      = 1'b0;
      capacity   = '0;
      min_size   = 32'd512;
      fail_count = 0;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fta_pkg::CFG_ENABLED:  fs_on = cfg_data[0];
          fta_pkg::CFG_CAPACITY: capacity = cfg_data;
          fta_pkg::CFG_MIN_SIZE: min_size = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          report("unexpected beat", 64'(out_ch.status), 64'hX);
        end else begin
          a = answers_due.pop_front();
          if (out_ch.status !== a.status)
            report("status", 64'(out_ch.status), 64'(a.status));
          if (out_ch.result_index !== a.index)
            report("index", 64'(out_ch.result_index), 64'(a.index));
          if (out_ch.file_offset !== a.offset)
            report("offset", 64'(out_ch.file_offset), 64'(a.offset));
          if (out_ch.result_size !== a.size)
            report("size", 64'(out_ch.result_size), 64'(a.size));
          if (out_ch.used_total !== a.used)
            report("used", 64'(out_ch.used_total), 64'(a.used));
        end
      end
      if (in_ch.valid && in_ch.ready)
        answers_due.push_back(apply_op(in_ch.operation, in_ch.file_name,
                                       in_ch.file_size, in_ch.entry_index));
    end
    open_count = answers_due.size();
  end

  final begin
    if (answers_due.size() != 0)
      $display("fta_checker: %0d results never arrived", answers_due.size());
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          open_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  logic        hold_done;
  int          cycles;

  fta_in_if  in_ch ();
  fta_out_if out_ch ();

  file_table_allocator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  fta_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .open_count(open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // give up on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [63:0] pool_name(input int n);
    return 64'h5A17_0000_0000_0000 ^ (64'(n) * 64'h9E37_79B9_7F4A_7C15);
  endfunction

  // offer one beat, idling first at random, and hold it until taken
  task automatic send(input fta_pkg::op_t op, input logic [63:0] name,
                      input logic [31:0] size, input logic [7:0] idx);
    logic taken;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.file_name   <= name;
    in_ch.file_size   <= size;
    in_ch.entry_index <= idx;
    taken = 1'b0;
    while (!taken) begin
      #4 taken = in_ch.ready;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input fta_pkg::cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic setup(input logic en, input logic [31:0] cap, input logic [31:0] minsz);
    quiesce();
    write_reg(fta_pkg::CFG_ENABLED, 32'(en));
    write_reg(fta_pkg::CFG_CAPACITY, cap);
    write_reg(fta_pkg::CFG_MIN_SIZE, minsz);
  endtask

  // mostly pool names and small sizes, so hits, reclaims and a full table occur
  task automatic random_ops(input int count, input int fmt_pct, input int pool);
    int           r;
    fta_pkg::op_t op;
    logic [63:0]  name;
    logic [31:0]  size;
    logic [7:0]   idx;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < fmt_pct)          op = fta_pkg::OP_FORMAT;
      else if (r < 70)          op = fta_pkg::OP_OPEN;
      else if (r < 82)          op = fta_pkg::OP_FIND;
      else                      op = fta_pkg::OP_DELETE;
      name = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                       : pool_name($urandom_range(pool - 1));
      case ($urandom_range(9))
        0:       size = $urandom;
        1:       size = 32'($urandom_range(70000));
        default: size = 32'($urandom_range(3000));
      endcase
      idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40));
      send(op, name, size, idx);
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = fta_pkg::OP_FORMAT;
    in_ch.file_name   = '0;
    in_ch.file_size   = '0;
    in_ch.entry_index = '0;
    cfg_we            = 1'b0;
    cfg_index         = fta_pkg::CFG_ENABLED;
    cfg_data          = '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_req          = 1'b0;
    rst_n             = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // disabled block answers everything with the off status
    send(fta_pkg::OP_FORMAT, '0, '0, '0);
    send(fta_pkg::OP_OPEN, pool_name(1), 32'd10, '0);
    setup(1'b1, 32'hFFFF_FFFF, 32'd512);

    // directed: hits, misses, deletes, reclaim, no space, extreme fields
    send(fta_pkg::OP_FORMAT, '0, '0, '0);
    send(fta_pkg::OP_OPEN, pool_name(1), 32'd0, '0);
    send(fta_pkg::OP_OPEN, pool_name(1), 32'd9999, '0);
    send(fta_pkg::OP_OPEN, pool_name(2), 32'd5000, '0);
    send(fta_pkg::OP_FIND, pool_name(2), '0, '0);
    send(fta_pkg::OP_FIND, pool_name(3), '0, '0);
    send(fta_pkg::OP_DELETE, '0, '0, 8'd0);
    send(fta_pkg::OP_DELETE, '0, '0, 8'd0);
    send(fta_pkg::OP_DELETE, '0, '0, 8'd200);
    send(fta_pkg::OP_OPEN, pool_name(3), 32'd100, '0);
    send(fta_pkg::OP_DELETE, '0, '0, 8'd1);
    send(fta_pkg::OP_OPEN, pool_name(4), 32'd3000, '0);
    send(fta_pkg::OP_FIND, pool_name(2), '0, '0);
    send(fta_pkg::OP_OPEN, pool_name(5), 32'hFFFF_FFFF, '0);
    send(fta_pkg::OP_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 32'd7, 8'hFF);
    send(fta_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send(fta_pkg::OP_DELETE, '0, '0, 8'd255);
    send(fta_pkg::OP_DELETE, '0, '0, 8'd2);
    send(fta_pkg::OP_FORMAT, '0, '0, '0);
    send(fta_pkg::OP_FIND, pool_name(1), '0, '0);

    // no format, large name pool: fills the table
    send_idle_pct = 38;
    recv_idle_pct = 82;
    random_ops(500, 0, 600);

    setup(1'b1, 32'd300000, 32'd0);
    send_idle_pct = 82;
    recv_idle_pct = 38;
    send(fta_pkg::OP_FORMAT, '0, '0, '0);
    random_ops(450, 2, 60);

    setup(1'b1, 32'd80000, 32'd4096);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    send(fta_pkg::OP_FORMAT, '0, '0, '0);
    random_ops(450, 2, 40);

    setup(1'b1, 32'd0, 32'hFFFF_FFFF);
    random_ops(200, 3, 20);

    setup(1'b0, 32'hFFFF_FFFF, 32'd0);
    random_ops(30, 5, 20);

    quiesce();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fta_pkg.sv
src/fta_if.sv
src/file_table_allocator_core.sv
tb/fta_checker.sv
tb/tb_top.sv
